// ===== sv/pbtp_pkg.sv =====
// Shared types and constants of the parameter block timeout parser.
`default_nettype none

package pbtp_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TagW    = 8;
  localparam int unsigned ValW    = 32;

  localparam logic [CfgIdxW-1:0] CFG_VERSION_TAG     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CONNECT_TAG     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEEPALIVE_TAG   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEF_CONNECT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEF_KEEPALIVE   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DEF_KEEPALIVE_F = 3'd5;

  localparam logic [TagW-1:0]        RST_VERSION_TAG   = 8'd1;
  localparam logic [TagW-1:0]        RST_CONNECT_TAG   = 8'd57;
  localparam logic [TagW-1:0]        RST_KEEPALIVE_TAG = 8'd58;
  localparam logic signed [ValW-1:0] RST_DEF_CONNECT   = 32'sd180;
  localparam logic signed [ValW-1:0] RST_DEF_KEEPALIVE = 32'sd60;

  localparam logic signed [ValW-1:0] FALLBACK_INTERVAL = 32'sd60;

  localparam logic [1:0] KIND_OTHER     = 2'd0;
  localparam logic [1:0] KIND_CONNECT   = 2'd1;
  localparam logic [1:0] KIND_KEEPALIVE = 2'd2;

  typedef struct packed {
    logic [TagW-1:0]        version_tag;
    logic [TagW-1:0]        connect_tag;
    logic [TagW-1:0]        keepalive_tag;
    logic signed [ValW-1:0] default_connect_timeout;
    logic signed [ValW-1:0] default_keepalive;
    logic                   default_keepalive_found;
  } cfg_t;

  typedef struct packed {
    logic signed [ValW-1:0] connect_timeout;
    logic signed [ValW-1:0] keepalive_interval;
    logic                   keepalive_set;
    logic                   truncated;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/pbtp_cfg.sv =====
// Configuration register file of the parameter block timeout parser.
`default_nettype none

module pbtp_cfg
  import pbtp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire logic [CfgIdxW-1:0] idx_i,
  input  wire logic [ValW-1:0]    data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (idx_i)
        CFG_VERSION_TAG:     cfg_d.version_tag             = data_i[TagW-1:0];
        CFG_CONNECT_TAG:     cfg_d.connect_tag             = data_i[TagW-1:0];
        CFG_KEEPALIVE_TAG:   cfg_d.keepalive_tag           = data_i[TagW-1:0];
        CFG_DEF_CONNECT:     cfg_d.default_connect_timeout = data_i;
        CFG_DEF_KEEPALIVE:   cfg_d.default_keepalive       = data_i;
        CFG_DEF_KEEPALIVE_F: cfg_d.default_keepalive_found = data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version_tag             <= RST_VERSION_TAG;
      cfg_q.connect_tag             <= RST_CONNECT_TAG;
      cfg_q.keepalive_tag           <= RST_KEEPALIVE_TAG;
      cfg_q.default_connect_timeout <= RST_DEF_CONNECT;
      cfg_q.default_keepalive       <= RST_DEF_KEEPALIVE;
      cfg_q.default_keepalive_found <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/pbtp_parser.sv =====
// Byte parser state and end-of-block result selection.
`default_nettype none

module pbtp_parser
  import pbtp_pkg::*;
#(
  parameter int unsigned VALUE_BYTES = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            mode_i,
  input  wire logic [TagW-1:0] byte_i,
  input  cfg_t                 cfg_i,
  output result_t              result_o
);

  localparam int unsigned KeepBytes = (VALUE_BYTES < 4) ? VALUE_BYTES : 4;
  localparam int unsigned IdxW      = $clog2(KeepBytes + 1);

  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_TAG     = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_VALUE   = 3'd3;
  localparam logic [2:0] PH_IGNORE  = 3'd4;

  logic [2:0]      phase_q, phase_d;
  logic [1:0]      kind_q, kind_d;
  logic [7:0]      left_q, left_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [ValW-1:0] acc_q, acc_d;
  logic [ValW-1:0] conn_q, conn_d;
  logic [ValW-1:0] keep_q, keep_d;
  logic [1:0]      seen_q, seen_d;
  logic            commit;
  logic [ValW-1:0] keep_pick;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    left_d  = left_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    conn_d  = conn_q;
    keep_d  = keep_q;
    seen_d  = seen_q;
    commit  = 1'b0;
    if (step_i && mode_i) begin
      phase_d = PH_VERSION;
      kind_d  = KIND_OTHER;
      left_d  = '0;
      idx_d   = '0;
      acc_d   = '0;
      conn_d  = '0;
      keep_d  = '0;
      seen_d  = '0;
    end else if (step_i) begin
      unique case (phase_q)
        PH_VERSION: begin
          phase_d = (byte_i == cfg_i.version_tag) ? PH_TAG : PH_IGNORE;
        end
        PH_TAG: begin
          if (byte_i == cfg_i.connect_tag) begin
            kind_d = KIND_CONNECT;
          end else if (byte_i == cfg_i.keepalive_tag) begin
            kind_d = KIND_KEEPALIVE;
          end else begin
            kind_d = KIND_OTHER;
          end
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          left_d = byte_i;
          idx_d  = '0;
          acc_d  = '0;
          if (byte_i == 8'd0) begin
            commit = 1'b1;
          end else begin
            phase_d = PH_VALUE;
          end
        end
        PH_VALUE: begin
          for (int k = 0; k < 4; k++) begin
            if (k < KeepBytes && kind_q != KIND_OTHER && idx_q == IdxW'(k)) begin
              acc_d[8*k +: 8] = byte_i;
            end
          end
          if (idx_q != IdxW'(KeepBytes)) begin
            idx_d = idx_q + 1'b1;
          end
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            commit = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IGNORE;
        end
      endcase
      if (commit) begin
        phase_d = PH_TAG;
        if (kind_q == KIND_CONNECT) begin
          conn_d    = acc_d;
          seen_d[0] = 1'b1;
        end else if (kind_q == KIND_KEEPALIVE) begin
          keep_d    = acc_d;
          seen_d[1] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VERSION;
      kind_q  <= KIND_OTHER;
      left_q  <= '0;
      idx_q   <= '0;
      acc_q   <= '0;
      conn_q  <= '0;
      keep_q  <= '0;
      seen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      conn_q  <= conn_d;
      keep_q  <= keep_d;
      seen_q  <= seen_d;
    end
  end

  always_comb begin
    keep_pick = seen_q[1] ? keep_q : cfg_i.default_keepalive;
    result_o.connect_timeout = seen_q[0] ? conn_q : cfg_i.default_connect_timeout;
    result_o.keepalive_interval = keep_pick[ValW-1] ? FALLBACK_INTERVAL : keep_pick;
    result_o.keepalive_set = seen_q[1] | cfg_i.default_keepalive_found;
    result_o.truncated = (phase_q == PH_LEN) || (phase_q == PH_VALUE);
  end

endmodule

`default_nettype wire

// ===== sv/parameter_block_timeout_parser_top.sv =====
// Top level of the parameter block timeout parser: input stage, result register, checks.
`default_nettype none

// Each beat on the input channel is either one byte of a tag-length-value
// parameter block or an end marker. Every beat is registered in the input
// stage and then parsed, so the block takes one beat per clock while no end
// marker is held up, and each parsed end marker yields one result beat.
// Only an end marker can be held up, when the result register is still full
// and not being taken. Configuration writes are accepted in every cycle and
// must be made only while the block is idle.
module parameter_block_timeout_parser_top
  import pbtp_pkg::*;
#(
  parameter int unsigned VALUE_BYTES = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [ValW-1:0]        cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   mode_i,
  input  wire logic [TagW-1:0]        block_byte_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [ValW-1:0]      connect_timeout_o,
  output logic signed [ValW-1:0]      keepalive_interval_o,
  output logic                        keepalive_set_o,
  output logic                        truncated_o
);

  cfg_t            cfg;
  result_t         result;
  result_t         res_q;
  logic            in_valid_q;
  logic            mode_q;
  logic [TagW-1:0] byte_q;
  logic            out_valid_q;
  logic            advance;

  assign cfg_ready_o = 1'b1;

  pbtp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign advance    = in_valid_q && (!mode_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q <= mode_i;
      byte_q <= block_byte_i;
    end
  end

  pbtp_parser #(
    .VALUE_BYTES (VALUE_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .mode_i   (mode_q),
    .byte_i   (byte_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && mode_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && mode_q) begin
      res_q <= result;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign connect_timeout_o    = res_q.connect_timeout;
  assign keepalive_interval_o = res_q.keepalive_interval;
  assign keepalive_set_o      = res_q.keepalive_set;
  assign truncated_o          = res_q.truncated;

`ifndef SYNTHESIS
  a_interval_not_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !keepalive_interval_o[ValW-1])
    else $error("keepalive interval is negative");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("empty input stage refuses a beat");

  a_result_from_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(advance && mode_q))
    else $error("result beat without an end marker");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the parameter block timeout parser.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbtp_pkg::*;

  localparam int unsigned VALUE_BYTES   = 4;
  localparam int unsigned ITEMS         = 1400;
  localparam int unsigned NUM_SETTINGS  = 6;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef enum logic [2:0] {
    PH_VERSION, PH_TAG, PH_LEN, PH_VALUE, PH_IGNORE
  } parse_phase_e;

  class timeout_board;
    cfg_t          regs;
    parse_phase_e  ph;
    logic [1:0]    kind;
    logic [7:0]    left;
    logic [7:0]    idx;
    logic [31:0]   acc;
    logic [31:0]   conn_val;
    logic [31:0]   keep_val;
    logic [1:0]    seen;
    result_t       due_results[$];
    int unsigned   errors;
    int unsigned   n_bytes;
    int unsigned   n_ends;
    int unsigned   n_results;
    int unsigned   n_trunc;
    int unsigned   n_kset;

    function new();
      regs = '{RST_VERSION_TAG, RST_CONNECT_TAG, RST_KEEPALIVE_TAG,
               RST_DEF_CONNECT, RST_DEF_KEEPALIVE, 1'b0};
      clear_parse();
    endfunction

    function void clear_parse();
      ph       = PH_VERSION;
      kind     = KIND_OTHER;
      left     = '0;
      idx      = '0;
      acc      = '0;
      conn_val = '0;
      keep_val = '0;
      seen     = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] index, logic [ValW-1:0] data);
      case (index)
        CFG_VERSION_TAG:     regs.version_tag = data[TagW-1:0];
        CFG_CONNECT_TAG:     regs.connect_tag = data[TagW-1:0];
        CFG_KEEPALIVE_TAG:   regs.keepalive_tag = data[TagW-1:0];
        CFG_DEF_CONNECT:     regs.default_connect_timeout = data;
        CFG_DEF_KEEPALIVE:   regs.default_keepalive = data;
        CFG_DEF_KEEPALIVE_F: regs.default_keepalive_found = data[0];
        default: ;
      endcase
    endfunction

    function void commit();
      if (kind == KIND_CONNECT) begin
        conn_val = acc;
        seen[0] = 1'b1;
      end else if (kind == KIND_KEEPALIVE) begin
        keep_val = acc;
        seen[1] = 1'b1;
      end
      ph = PH_TAG;
    endfunction

    task report_mismatch(string what);
      if (errors < 40) $display("MISMATCH: %s", what);
      errors++;
    endtask

    task take_beat(logic end_mark, logic [7:0] b);
      result_t r;
      if (end_mark == MODE_BYTE) begin
        n_bytes++;
        case (ph)
          PH_VERSION: ph = (b == regs.version_tag) ? PH_TAG : PH_IGNORE;
          PH_TAG: begin
            if (b == regs.connect_tag) kind = KIND_CONNECT;
            else if (b == regs.keepalive_tag) kind = KIND_KEEPALIVE;
            else kind = KIND_OTHER;
            ph = PH_LEN;
          end
          PH_LEN: begin
            left = b;
            idx  = '0;
            acc  = '0;
            if (b == 8'd0) commit();
            else ph = PH_VALUE;
          end
          PH_VALUE: begin
            if (kind != KIND_OTHER && idx < VALUE_BYTES && idx < 4)
              acc |= 32'(b) << (8 * idx);
            if (idx != 8'hFF) idx++;
            left--;
            if (left == 8'd0) commit();
          end
          default: ph = PH_IGNORE;
        endcase
      end else begin
        n_ends++;
        r.truncated       = (ph == PH_LEN || ph == PH_VALUE);
        r.connect_timeout = seen[0] ? conn_val : regs.default_connect_timeout;
        if (seen[1]) begin
          r.keepalive_interval = keep_val;
          r.keepalive_set      = 1'b1;
        end else begin
          r.keepalive_interval = regs.default_keepalive;
          r.keepalive_set      = regs.default_keepalive_found;
        end
        if (r.keepalive_interval < 0) r.keepalive_interval = FALLBACK_INTERVAL;
        due_results.push_back(r);
        clear_parse();
      end
    endtask

    task match_result(logic [ValW-1:0] conn, logic [ValW-1:0] keep, logic kset,
                      logic trunc);
      result_t want;
      if (due_results.size() == 0) begin
        report_mismatch("result beat arrived with nothing expected");
        return;
      end
      want = due_results.pop_front();
      n_results++;
      if (want.truncated) n_trunc++;
      if (want.keepalive_set) n_kset++;
      if (conn !== want.connect_timeout)
        report_mismatch($sformatf("connect_timeout %h, expected %h",
                                  conn, want.connect_timeout));
      if (keep !== want.keepalive_interval)
        report_mismatch($sformatf("keepalive_interval %h, expected %h",
                                  keep, want.keepalive_interval));
      if (kset !== want.keepalive_set)
        report_mismatch($sformatf("keepalive_set %b, expected %b",
                                  kset, want.keepalive_set));
      if (trunc !== want.truncated)
        report_mismatch($sformatf("truncated %b, expected %b",
                                  trunc, want.truncated));
    endtask
  endclass

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               cfg_valid   = 1'b0;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [ValW-1:0]    cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               mode        = MODE_BYTE;
  logic [TagW-1:0]    block_byte  = '0;
  logic               out_ready   = 1'b0;

  logic                   cfg_ready_o;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic signed [ValW-1:0] connect_timeout_o;
  logic signed [ValW-1:0] keepalive_interval_o;
  logic                   keepalive_set_o;
  logic                   truncated_o;

  timeout_board board = new();

  bit          tx_burst  = 1'b0;
  bit          rx_quiet  = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned items_sent;
  int unsigned cycles;
  int unsigned settings_used;

  parameter_block_timeout_parser_top #(
    .VALUE_BYTES(VALUE_BYTES)
  ) i_dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready_o),
    .mode_i               (mode),
    .block_byte_i         (block_byte),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready),
    .connect_timeout_o    (connect_timeout_o),
    .keepalive_interval_o (keepalive_interval_o),
    .keepalive_set_o      (keepalive_set_o),
    .truncated_o          (truncated_o)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) board.take_beat(mode, block_byte);
      if (out_valid_o && out_ready)
        board.match_result(connect_timeout_o, keepalive_interval_o,
                           keepalive_set_o, truncated_o);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles,
               board.due_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Unless quiet, the receiver stalls a drawn number of cycles before each result
  // beat, and once for a long stretch when asked, so that the input side backs up.
  initial begin
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        hold = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        hold = rx_quiet ? 0 : $urandom_range(0, 16);
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid_o);
      if ($urandom_range(0, 7) == 0) rx_quiet = !rx_quiet;
    end
  end

  task automatic send_beat(input logic end_mark, input logic [7:0] b);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= end_mark;
    block_byte <= b;
    do @(posedge clk); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_block_bytes(input logic [7:0] seq[$], input int unsigned cnt);
    for (int unsigned i = 0; i < cnt; i++) send_beat(MODE_BYTE, seq[i]);
    send_beat(MODE_END, 8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [ValW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    board.write_reg(index, data);
  endtask

  task automatic write_all(input cfg_t s);
    write_reg(CFG_VERSION_TAG, 32'(s.version_tag));
    write_reg(CFG_CONNECT_TAG, 32'(s.connect_tag));
    write_reg(CFG_KEEPALIVE_TAG, 32'(s.keepalive_tag));
    write_reg(CFG_DEF_CONNECT, s.default_connect_timeout);
    write_reg(CFG_DEF_KEEPALIVE, s.default_keepalive);
    write_reg(CFG_DEF_KEEPALIVE_F, 32'(s.default_keepalive_found));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed blocks with random content; some carry a wrong version
  // byte, some are cut short, and some are plain noise.
  task automatic send_block();
    logic [7:0]  seq[$];
    int unsigned n_params;
    int unsigned len;
    int unsigned pick;
    int unsigned cnt;
    tx_burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 8)) seq.push_back(8'($urandom));
    end else begin
      seq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                : board.regs.version_tag);
      n_params = $urandom_range(0, 4);
      repeat (n_params) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) seq.push_back(board.regs.connect_tag);
        else if (pick == 1) seq.push_back(board.regs.keepalive_tag);
        else seq.push_back(8'($urandom));
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 255)
                                           : $urandom_range(0, 6);
        seq.push_back(8'(len));
        repeat (len) seq.push_back(8'($urandom));
      end
    end
    cnt = seq.size();
    if ($urandom_range(0, 5) == 0) cnt = $urandom_range(0, cnt);
    send_block_bytes(seq, cnt);
  endtask

  initial begin
    cfg_t       s;
    logic [7:0] blk[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p == 0) begin
        blk = '{};
        send_block_bytes(blk, 0);
        blk = '{RST_VERSION_TAG, RST_CONNECT_TAG, 8'd4, 8'h00, 8'hFF, 8'hFF, 8'h7F};
        send_block_bytes(blk, blk.size());
        blk = '{RST_VERSION_TAG, RST_KEEPALIVE_TAG, 8'd6, 8'h01, 8'h02, 8'h03,
                8'h84, 8'h55, 8'h66, RST_CONNECT_TAG, 8'd0};
        send_block_bytes(blk, blk.size());
        blk = '{8'h00, RST_CONNECT_TAG};
        send_block_bytes(blk, blk.size());
        blk = '{RST_VERSION_TAG, RST_CONNECT_TAG};
        send_block_bytes(blk, blk.size());

        // Back-to-back short blocks while the receiver holds off.
        wait_idle();
        long_hold = 1'b1;
        tx_burst  = 1'b1;
        repeat (20) begin
          blk = '{RST_VERSION_TAG, RST_KEEPALIVE_TAG, 8'd1, 8'($urandom)};
          send_block_bytes(blk, blk.size());
        end
        wait_idle();
      end else begin
        wait_idle();
        case (p)
          1: s = '{8'h00, 8'hFF, 8'h00, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1};
          2: begin
            s = '{8'hFF, 8'd77, 8'd77, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0};
            write_reg(CFG_SPARE_LO, $urandom);
            write_reg(CFG_SPARE_HI, $urandom);
          end
          default: begin
            s.version_tag             = 8'($urandom);
            s.connect_tag             = 8'($urandom);
            s.keepalive_tag           = ($urandom_range(0, 3) == 0) ? s.connect_tag
                                                                    : 8'($urandom);
            s.default_connect_timeout = $urandom;
            s.default_keepalive       = $urandom;
            s.default_keepalive_found = 1'($urandom);
          end
        endcase
        write_all(s);
      end
      while (items_sent < ITEMS * (p + 1) / NUM_SETTINGS) send_block();
    end

    wait_idle();
    if (board.due_results.size() != 0)
      board.report_mismatch("expected results left over at the end");
    $display("Run covered %0d block bytes and %0d end markers over %0d register settings.",
             board.n_bytes, board.n_ends, settings_used + 1);
    $display("Checked %0d results: %0d truncated, %0d with keepalive set, %0d mismatches.",
             board.n_results, board.n_trunc, board.n_kset, board.errors);
    if (board.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
